// ===== hw/rtl/depq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depq_pkg - shared types and constants
// Entry, cell control, request and response types, action and status codes,
// and sizes for the sorted priority queue.
// ----------------------------------------------------------------------------
package depq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    localparam logic [1:0] ACT_INSERT   = 2'd0;
    localparam logic [1:0] ACT_REM_HIGH = 2'd1;
    localparam logic [1:0] ACT_REM_LOW  = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [31:0] pri;
        logic signed [31:0] elem;
    } t_entry;

    typedef struct packed {
        logic        ins;
        logic        pull;
        logic        occ;
    } t_cell_ctl;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] element_in;
        logic signed [31:0] priority_in;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element_out;
        logic               queue_empty;
    } t_rsp;

endpackage

// ===== hw/rtl/depq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depq_cell - one slot of the sorted chain
// Holds one entry, compares it with the incoming priority and takes the new
// entry, its left neighbour or its right neighbour as the request demands.
// ----------------------------------------------------------------------------
module depq_cell (
    input  logic             i_clk,
    input  depq_pkg::t_cell_ctl i_ctl,
    input  depq_pkg::t_entry i_new,
    input  depq_pkg::t_entry i_left,
    input  logic             i_left_lt,
    input  depq_pkg::t_entry i_right,
    output depq_pkg::t_entry o_entry,
    output logic             o_lt
);
    import depq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    assign o_lt    = i_ctl.occ && ($signed(r_entry.pri) < $signed(i_new.pri));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (!o_lt) begin
                n_entry = i_left_lt ? i_new : i_left;
            end
        end else if (i_ctl.pull) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== hw/rtl/double_ended_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_priority_queue_unit - sorted double-ended priority queue
// Keeps up to DEPTH entries sorted ascending by priority in a chain of cells.
//
// Usage:
//   A request (i_req: action, element, priority) is taken at a rising edge
//   with start high and busy low. Insert places the entry before the first
//   stored entry of greater or equal priority; remove-lowest pops the head,
//   remove-highest pops the tail.
//   Exactly one response (o_rsp: status, element, empty flag) follows, held
//   for one cycle with o_done high, registered at the request edge.
//   Throughput is one request per cycle: every cell compares and shifts in
//   parallel, so busy stays low.
//   The receiver cannot stall; o_done is a one-cycle strobe.
//   Reset clears the entry count and o_done; cell contents are not cleared
//   and are only read below the count.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  depq_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output depq_pkg::t_rsp o_rsp
);
    import depq_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    t_rsp             r_rsp;
    t_rsp             n_rsp;

    logic             w_ins;
    logic             w_pull;
    logic             w_acc;
    logic [IDX_W-1:0] w_tail_idx;
    t_entry           w_new;
    t_entry           w_entry [DEPTH];
    logic             w_lt    [DEPTH];

    assign busy   = 1'b0;
    assign w_acc  = start && !busy;
    assign w_new  = '{pri: i_req.priority_in, elem: i_req.element_in};
    assign w_tail_idx = IDX_W'(r_count - CNT_W'(1));

    always_comb begin
        n_count = r_count;
        w_ins   = 1'b0;
        w_pull  = 1'b0;
        n_rsp   = '{status: ST_DONE, element_out: '0, queue_empty: 1'b0};
        case (i_req.action)
            ACT_INSERT: begin
                if (r_count == CNT_W'(DEPTH)) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    w_ins   = w_acc;
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_REM_HIGH: begin
                if (r_count == '0) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_rsp.element_out = w_entry[w_tail_idx].elem;
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                if (r_count == '0) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_rsp.element_out = w_entry[0].elem;
                    w_pull  = w_acc;
                    n_count = r_count - CNT_W'(1);
                end
            end
        endcase
        n_rsp.queue_empty = (n_count == '0);
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctl w_ctl;
        t_entry    w_left;
        t_entry    w_right;
        logic      w_left_lt;

        assign w_ctl = '{ins: w_ins, pull: w_pull, occ: (r_count > CNT_W'(g))};

        if (g == 0) begin : g_head
            assign w_left    = w_new;
            assign w_left_lt = 1'b1;
        end else begin : g_mid
            assign w_left    = w_entry[g-1];
            assign w_left_lt = w_lt[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end

        depq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_new     (w_new),
            .i_left    (w_left),
            .i_left_lt (w_left_lt),
            .i_right   (w_right),
            .o_entry   (w_entry[g]),
            .o_lt      (w_lt[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= w_acc;
            if (w_acc) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> o_done)
        else $error("request without response");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> !o_done)
        else $error("response without request");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.queue_empty == (r_count == '0)))
        else $error("empty flag disagrees with count");

    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status != ST_DONE)) |-> (o_rsp.element_out == '0))
        else $error("element on failed request");
`endif

endmodule
